// ===== sv/rbfi_pkg.sv =====
`default_nettype none
package rbfi_pkg;
    localparam int NUM_AXES  = 3;
    localparam int NUM_FACES = 6;
    localparam int EPS_W     = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
endpackage
`default_nettype wire

// ===== sv/rbfi_req_if.sv =====
`default_nettype none
interface rbfi_req_if #(parameter int COORD_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/rbfi_rsp_if.sv =====
`default_nettype none
interface rbfi_rsp_if #(parameter int COORD_WIDTH = 32);
    logic valid;
    logic ready;
    logic hit;
    logic signed [COORD_WIDTH-1:0] t_hit;

    modport source (output valid, hit, t_hit, input ready);
    modport sink (input valid, hit, t_hit, output ready);
endinterface
`default_nettype wire

// ===== sv/rbfi_div.sv =====
`default_nettype none
// Pipelined unsigned restoring divider: one quotient bit per register stage.
module rbfi_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [COORD_WIDTH+FRAC_BITS-1:0] num,
    input  wire logic [COORD_WIDTH-1:0]           den,
    output logic      [COORD_WIDTH+FRAC_BITS-1:0] quo
);
    localparam int W  = COORD_WIDTH;
    localparam int QB = COORD_WIDTH + FRAC_BITS;

    logic [W-1:0]  rem_reg [0:QB-1];
    logic [QB-1:0] num_reg [0:QB-1];
    logic [W-1:0]  den_reg [0:QB-1];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [W-1:0]  rem_in;
            logic [QB-1:0] num_in;
            logic [W-1:0]  den_in;
            logic [W:0]    part;
            logic [W+1:0]  diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign den_in = den;
            end else begin : g_next
                assign rem_in = rem_reg[k-1];
                assign num_in = num_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            always_comb
            begin
                part = {rem_in, num_in[QB-1]};
                diff = {1'b0, part} - {2'b00, den_in};
                ge   = ~diff[W+1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[W-1:0] : part[W-1:0];
                    num_reg[k] <= {num_in[QB-2:0], ge};
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = num_reg[QB-1];
endmodule
`default_nettype wire

// ===== sv/ray_box_face_intersect_core.sv =====
`default_nettype none
// Ray against axis-aligned box test, one ray/box pair per transfer on req.
// The req channel carries origin, direction and both box corners in signed
// fixed point; the rsp channel returns the hit flag and the smallest face
// parameter t (largest positive value when nothing is hit).
// cfg_we with cfg_wdata writes the parallel epsilon; write it only while idle.
// A result passes the input register, the six pipelined dividers that produce
// one quotient bit per stage, and the t, product, hit point, hit flag, pair and
// output registers. Throughput is one item per cycle while req.ready is high.
// The pipeline advances as a whole while its output skid register is empty.
// When the receiver stalls, the finished result stays in the output register,
// the next one lands in the skid register, and only then req.ready drops.
// Reset empties the pipeline and sets the epsilon to 7; no stored state
// needs clearing.
module ray_box_face_intersect_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    rbfi_req_if.sink                       req,
    rbfi_rsp_if.source                     rsp,
    input  wire logic                      cfg_we,
    input  wire logic [rbfi_pkg::EPS_W-1:0] cfg_wdata
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QB = W + F;
    localparam int PW = 2*W - F + 1;
    localparam int NF = rbfi_pkg::NUM_FACES;
    localparam int NA = rbfi_pkg::NUM_AXES;
    localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [NA-1:0][W-1:0] o;
        logic [NA-1:0][W-1:0] d;
        logic [NA-1:0][W-1:0] lo;
        logic [NA-1:0][W-1:0] hi;
        logic [NA-1:0]        axis_en;
        logic [NF-1:0]        neg;
    } item_t;

    typedef struct packed {
        logic         hit;
        logic [W-1:0] t;
    } cand_t;

    logic [rbfi_pkg::EPS_W-1:0] eps_reg;
    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= rbfi_pkg::EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    // Input preparation: face numerators and divisor magnitudes.
    item_t item_in;
    logic [NA-1:0][W-1:0]  o_in;
    logic [NA-1:0][W-1:0]  d_in;
    logic [NA-1:0][W-1:0]  lo_in;
    logic [NA-1:0][W-1:0]  hi_in;
    logic [NA-1:0]         axis_en_next;
    logic [NF-1:0]         neg_next;
    logic [NF-1:0][QB-1:0] num_next;
    logic [NA-1:0][W-1:0]  den_next;
    logic [NF-1:0][QB-1:0] num_reg;
    logic [NA-1:0][W-1:0]  den_reg;

    assign o_in  = {req.origin_z, req.origin_y, req.origin_x};
    assign d_in  = {req.dir_z, req.dir_y, req.dir_x};
    assign lo_in = {req.box_min_z, req.box_min_y, req.box_min_x};
    assign hi_in = {req.box_max_z, req.box_max_y, req.box_max_x};

    always_comb
    begin
        item_in.o       = o_in;
        item_in.d       = d_in;
        item_in.lo      = lo_in;
        item_in.hi      = hi_in;
        item_in.axis_en = axis_en_next;
        item_in.neg     = neg_next;
    end

    genvar f, a;
    generate
        for (a = 0; a < NA; a++) begin : g_axis
            assign den_next[a] = d_in[a][W-1] ? (W)'(-d_in[a]) : d_in[a];
            assign axis_en_next[a] = den_next[a] > {{(W-rbfi_pkg::EPS_W){1'b0}}, eps_reg};
        end
        for (f = 0; f < NF; f++) begin : g_prep
            localparam int AX = f / 2;
            logic signed [W:0] diff;
            logic [W:0]        dmag;
            always_comb
            begin
                diff = (f % 2 == 1)
                     ? $signed({hi_in[AX][W-1], hi_in[AX]})
                       - $signed({o_in[AX][W-1], o_in[AX]})
                     : $signed({lo_in[AX][W-1], lo_in[AX]})
                       - $signed({o_in[AX][W-1], o_in[AX]});
                dmag = diff[W] ? (W+1)'(-diff) : diff;
            end
            assign num_next[f] = {dmag[W-1:0], {F{1'b0}}};
            assign neg_next[f] = diff[W] ^ d_in[AX][W-1];
        end
    endgenerate

    logic  vld_reg  [0:QB];
    item_t item_reg [0:QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= item_in;
            num_reg     <= num_next;
            den_reg     <= den_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= req.valid;
    end

    generate
        for (genvar k = 1; k <= QB; k++) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                    item_reg[k] <= item_reg[k-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    endgenerate

    logic [NF-1:0][QB-1:0] quo;
    generate
        for (f = 0; f < NF; f++) begin : g_div
            rbfi_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div (
                .clk (clk),
                .en  (en),
                .num (num_reg[f]),
                .den (den_reg[f/2]),
                .quo (quo[f])
            );
        end
    endgenerate

    // Saturate, multiply, hit point, bound test.
    logic  t_vld_reg, m_vld_reg, p_vld_reg, c_vld_reg, r_vld_reg;
    item_t t_item_reg, m_item_reg, p_item_reg;
    logic [NF-1:0][W-1:0] t_reg, m_t_reg, p_t_reg, c_t_reg;
    logic [NF-1:0][1:0][2*W-1:0] prod_reg;
    logic [NF-1:0][1:0][PW-1:0]  pt_reg;
    logic [NF-1:0] c_hit_reg;
    cand_t [2:0] r_cand_reg;

    logic [NF-1:0][W-1:0]        t_next;
    logic [NF-1:0][1:0][2*W-1:0] prod_next;
    logic [NF-1:0][1:0][PW-1:0]  pt_next;
    logic [NF-1:0]               hit_next;

    generate
        for (f = 0; f < NF; f++) begin : g_face
            localparam int AX = f / 2;
            localparam int B  = (AX + 1) % 3;
            localparam int C  = (AX + 2) % 3;
            logic big, exact_min;
            assign big       = |quo[f][QB-1:W-1];
            assign exact_min = quo[f][W-1] && ~|quo[f][QB-1:W] && ~|quo[f][W-2:0];
            assign t_next[f] = item_reg[QB].neg[f]
                             ? ((big && !exact_min) ? TMIN : (W)'(-quo[f][W-1:0]))
                             : (big ? TMAX : quo[f][W-1:0]);

            assign prod_next[f][0] = $signed(t_reg[f]) * $signed(t_item_reg.d[B]);
            assign prod_next[f][1] = $signed(t_reg[f]) * $signed(t_item_reg.d[C]);

            for (genvar j = 0; j < 2; j++) begin : g_pt
                localparam int OX = (j == 0) ? B : C;
                logic signed [2*W-1:0] sh;
                assign sh = $signed(prod_reg[f][j]) >>> F;
                assign pt_next[f][j] = (PW)'($signed(m_item_reg.o[OX]))
                                     + (PW)'($signed(sh[2*W-F-1:0]));
            end

            assign hit_next[f] = p_item_reg.axis_en[AX]
                && ($signed(pt_reg[f][0]) >= (PW)'($signed(p_item_reg.lo[B])))
                && ($signed(pt_reg[f][0]) <= (PW)'($signed(p_item_reg.hi[B])))
                && ($signed(pt_reg[f][1]) >= (PW)'($signed(p_item_reg.lo[C])))
                && ($signed(pt_reg[f][1]) <= (PW)'($signed(p_item_reg.hi[C])));
        end
    endgenerate

    function automatic cand_t pick(input cand_t x, input cand_t y);
        cand_t r;
        if (x.hit && y.hit)
            r = ($signed(y.t) < $signed(x.t)) ? y : x;
        else if (y.hit)
            r = y;
        else if (x.hit)
            r = x;
        else
            r = '{hit: 1'b0, t: TMAX};
        return r;
    endfunction

    cand_t [2:0] pair_next;
    cand_t       res;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pair_next[i] = pick('{hit: c_hit_reg[2*i], t: c_t_reg[2*i]},
                                '{hit: c_hit_reg[2*i+1], t: c_t_reg[2*i+1]});
        res = pick(pick(r_cand_reg[0], r_cand_reg[1]), r_cand_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= t_next;
            t_item_reg <= item_reg[QB];
            m_t_reg    <= t_reg;
            prod_reg   <= prod_next;
            m_item_reg <= t_item_reg;
            p_t_reg    <= m_t_reg;
            pt_reg     <= pt_next;
            p_item_reg <= m_item_reg;
            c_t_reg    <= p_t_reg;
            c_hit_reg  <= hit_next;
            r_cand_reg <= pair_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            t_vld_reg <= vld_reg[QB];
            m_vld_reg <= t_vld_reg;
            p_vld_reg <= m_vld_reg;
            c_vld_reg <= p_vld_reg;
            r_vld_reg <= c_vld_reg;
        end
    end

    // Output register with one skid entry behind it.
    logic  out_vld_reg, skid_vld_reg;
    cand_t out_reg, skid_reg;

    assign en        = ~skid_vld_reg;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (rsp.ready)
                skid_vld_reg <= 1'b0;
        end
        else if (r_vld_reg)
        begin
            if (out_vld_reg && !rsp.ready)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (rsp.ready)
                out_reg <= skid_reg;
        end
        else if (r_vld_reg)
        begin
            if (out_vld_reg && !rsp.ready)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.hit   = out_reg.hit;
    assign rsp.t_hit = out_reg.t;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held without an output result");

    a_miss_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.hit) |-> (out_reg.t == TMAX))
        else $error("missed test returned a t other than the maximum");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");
endmodule
`default_nettype wire

// ===== tb/tb_rbfi_channels_if.sv =====
`timescale 1ns / 100ps
// The block's own channel interfaces (rbfi_req_if, rbfi_rsp_if) are used directly;
// this file holds the ray/box record type that the top uses for its stimulus.
package tb_rbfi_types_pkg;
    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
    } ray_box_t;
endpackage

// ===== tb/tb_rbfi_checker.sv =====
`timescale 1ns / 100ps
module tb_rbfi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    rbfi_req_if             req,
    rbfi_rsp_if             rsp,
    input wire logic        cfg_we,
    input wire logic [15:0] cfg_wdata,
    output int              errors,
    output int              pending,
    output int              hits_seen,
    output int              results_seen
);
    localparam longint T_MAX = 64'sd2147483647;
    localparam longint T_MIN = -64'sd2147483648;

    logic [15:0] epsilon;
    logic [32:0] expected_q[$];

    function automatic longint floor_shift(longint prod);
        if (prod >= 0)
            return prod / 65536;
        return -((-prod + 65535) / 65536);
    endfunction

    function automatic logic [32:0] box_test(longint o[3], longint d[3],
                                             longint lo[3], longint hi[3]);
        longint best;
        longint t, pb, pc, mag, plane;
        bit any;
        int b, c;
        best = T_MAX;
        any = 0;
        for (int a = 0; a < 3; a++)
        begin
            b = (a + 1) % 3;
            c = (a + 2) % 3;
            mag = d[a] < 0 ? -d[a] : d[a];
            if (mag > longint'(epsilon))
            begin
                for (int f = 0; f < 2; f++)
                begin
                    plane = f ? hi[a] : lo[a];
                    t = ((plane - o[a]) * 65536) / d[a];
                    if (t > T_MAX) t = T_MAX;
                    if (t < T_MIN) t = T_MIN;
                    pb = o[b] + floor_shift(t * d[b]);
                    pc = o[c] + floor_shift(t * d[c]);
                    if (pb >= lo[b] && pb <= hi[b] && pc >= lo[c] && pc <= hi[c])
                    begin
                        if (!any || t < best) best = t;
                        any = 1;
                    end
                end
            end
        end
        return {any, best[31:0]};
    endfunction

    task automatic report(string what, logic [32:0] want, logic got_hit, logic [31:0] got_t);
        errors++;
        $display("MISMATCH %s: expected hit=%0d t=%h, got hit=%0d t=%h",
                 what, want[32], want[31:0], got_hit, got_t);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint o[3], d[3], lo[3], hi[3];
        logic [32:0] want;
        if (!rst_n)
        begin
            epsilon = 16'd7;
            expected_q.delete();
            errors = 0;
            hits_seen = 0;
            results_seen = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (rsp.hit) hits_seen++;
                if (expected_q.size() == 0)
                    report("unexpected result", 33'd0, rsp.hit, rsp.t_hit);
                else
                begin
                    want = expected_q.pop_front();
                    if (want[32] !== rsp.hit)
                        report("hit flag", want, rsp.hit, rsp.t_hit);
                    else if (want[31:0] !== rsp.t_hit)
                        report("t_hit", want, rsp.hit, rsp.t_hit);
                end
            end
            if (req.valid && req.ready)
            begin
                o = '{req.origin_x, req.origin_y, req.origin_z};
                d = '{req.dir_x, req.dir_y, req.dir_z};
                lo = '{req.box_min_x, req.box_min_y, req.box_min_z};
                hi = '{req.box_max_x, req.box_max_y, req.box_max_z};
                expected_q.push_back(box_test(o, d, lo, hi));
            end
            if (cfg_we)
                epsilon = cfg_wdata;
        end
        pending = expected_q.size();
    end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    localparam int LATENCY = 55;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [15:0] cfg_wdata = 0;
    int errors, pending, hits_seen, results_seen;
    int cycles = 0;
    int sent = 0;
    bit long_stall = 0;

    rbfi_req_if #(32) req ();
    rbfi_rsp_if #(32) rsp ();

    ray_box_face_intersect_core #(.COORD_WIDTH(32), .FRAC_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata));

    tb_rbfi_checker chk (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending),
        .hits_seen(hits_seen), .results_seen(results_seen));

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        req.valid = 0;
        {req.origin_x, req.origin_y, req.origin_z, req.dir_x, req.dir_y, req.dir_z,
         req.box_min_x, req.box_min_y, req.box_min_z,
         req.box_max_x, req.box_max_y, req.box_max_z} = '0;
    end

    // Receiver: random stalls between results, or a long hold-off.
    initial
    begin
        int gap;
        rsp.ready = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                rsp.ready = 0;
                repeat (200) @(negedge clk);
                long_stall = 0;
            end
            gap = (($urandom_range(0, 3) == 0) || sent < 30) ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                rsp.ready = 0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                rsp.ready = 1;
                @(posedge clk);
                while (!rsp.valid) @(posedge clk);
            end
        end
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    task automatic send(tb_rbfi_types_pkg::ray_box_t item);
        @(negedge clk);
        {req.origin_x, req.origin_y, req.origin_z, req.dir_x, req.dir_y, req.dir_z,
         req.box_min_x, req.box_min_y, req.box_min_z,
         req.box_max_x, req.box_max_y, req.box_max_z} = item;
        req.valid = 1;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_idle(tb_rbfi_types_pkg::ray_box_t item);
        int gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            @(negedge clk);
            req.valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
        send(item);
    endtask

    task automatic drain_and_config(logic [15:0] value);
        @(negedge clk);
        req.valid = 0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        @(negedge clk);
        cfg_we = 1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 0;
    endtask

    function automatic tb_rbfi_types_pkg::ray_box_t random_ray(int mode);
        tb_rbfi_types_pkg::ray_box_t r;
        logic [31:0] a, b;
        r.ox = rand_coord(mode); r.oy = rand_coord(mode); r.oz = rand_coord(mode);
        r.dx = rand_coord(mode); r.dy = rand_coord(mode); r.dz = rand_coord(mode);
        a = rand_coord(mode); b = rand_coord(mode);
        {r.lx, r.hx} = ($signed(a) <= $signed(b) || $urandom_range(0, 9) == 0) ? {a, b} : {b, a};
        a = rand_coord(mode); b = rand_coord(mode);
        {r.ly, r.hy} = ($signed(a) <= $signed(b) || $urandom_range(0, 9) == 0) ? {a, b} : {b, a};
        a = rand_coord(mode); b = rand_coord(mode);
        {r.lz, r.hz} = ($signed(a) <= $signed(b) || $urandom_range(0, 9) == 0) ? {a, b} : {b, a};
        // Often aim the ray at the box so that many faces are hit.
        if ($urandom_range(0, 2) != 0 && mode != 0)
        begin
            r.dx = r.lx + ((r.hx - r.lx) >>> 1) - r.ox;
            r.dy = r.ly + ((r.hy - r.ly) >>> 1) - r.oy;
            r.dz = r.lz + ((r.hz - r.lz) >>> 1) - r.oz;
        end
        if ($urandom_range(0, 7) == 0) r.dy = $urandom_range(0, 14) - 7;
        return r;
    endfunction

    initial
    begin
        localparam logic [31:0] MX = 32'h7FFF_FFFF;
        localparam logic [31:0] MN = 32'h8000_0000;
        localparam logic [31:0] ONE = 32'h0001_0000;
        tb_rbfi_types_pkg::ray_box_t directed[$];
        logic [15:0] eps_list[4];
        eps_list = '{16'd0, 16'hFFFF, 16'd100, 16'd7};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Box from -1 to 1 around the origin: rays along each axis, from inside, parallel, inverted; then extremes.
        directed.push_back('{-2*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{0, -2*ONE, 0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{0, 0, 2*ONE, 0, 0, -ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{5*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{-2*ONE, 0, 0, 7, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{-2*ONE, 0, 0, 8, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{-2*ONE, 0, 0, -8, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{-2*ONE, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE});
        directed.push_back('{-2*ONE, 3*ONE, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{-2*ONE, ONE, ONE, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
        directed.push_back('{MN, 0, 0, 8, 0, 0, MX, MN, MN, MX, MX, MX});
        directed.push_back('{MX, MX, MX, MN, MN, MN, MN, MN, MN, MX, MX, MX});
        directed.push_back('{MN, MN, MN, MX, MX, MX, MN, MN, MN, MX, MX, MX});
        directed.push_back('{0, 0, 0, MN, 1, -1, MN, MN, MN, MX, MX, MX});
        directed.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
        directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{-ONE, 0, 0, 3, 5, 9, MN, MN, MN, MX, MX, MX});
        foreach (directed[i]) send(directed[i]);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_and_config(eps_list[phase]);
            if (phase == 1) long_stall = 1;
            for (int i = 0; i < 283; i++)
            begin
                if (phase == 1 && i < 120)
                    send(random_ray($urandom_range(0, 2)));
                else
                    send_idle(random_ray($urandom_range(0, 2)));
            end
        end
        @(negedge clk);
        req.valid = 0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d ray/box tests over 4 epsilon settings (0, 65535, 100, 7).",
                 sent);
        $display("Checked %0d results, %0d with a hit; %0d mismatches.",
                 results_seen, hits_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
